[hdl/hmn_pkg.sv]
// shared types, constants and register map of the height map to normal map block
package hmn_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int ROW_W      = 8;
  localparam int COL_W      = 8;
  localparam int SMP_W      = 8;
  localparam int DIM_W      = 9;
  localparam int SCALE_W    = 16;

  localparam int DIFF_W = 25;
  localparam int SQ_W   = 48;
  localparam int ROOT_W = 24;
  localparam int NUM_W  = 31;
  localparam int Q_W    = 7;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
  localparam logic [SQ_W-1:0]  UNIT_Z_SQ = 48'd4261478400;
  localparam logic [NUM_W-1:0] NUM_Z     = 31'd8290560;
  localparam logic [7:0]       ALPHA     = 8'd255;
  localparam logic [7:0]       BIAS      = 8'd128;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam int             APB_ADDR_W = 4;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;
  localparam logic [1:0] REG_WRAP   = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
    logic signed [SCALE_W-1:0] scale;
    logic                      wrap;
  } hmn_cfg_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dxn;
    logic signed [DIFF_W-1:0] dyn;
    logic [SQ_W-1:0]          radicand;
  } hmn_grad_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dxn;
    logic signed [DIFF_W-1:0] dyn;
    logic [ROOT_W-1:0]        root;
  } hmn_len_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
  } hmn_rgb_t;

endpackage

[hdl/hmn_if.sv]
// valid/ready channel interfaces for request items and normal items
interface hmn_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] row;
  logic [7:0] col;
  logic [7:0] height_sample;
  modport source(output valid, opcode, row, col, height_sample, input ready);
  modport sink(input valid, opcode, row, col, height_sample, output ready);
endinterface

interface hmn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] normal_x;
  logic [7:0] normal_y;
  logic [7:0] normal_z;
  logic [7:0] alpha;
  modport source(output valid, normal_x, normal_y, normal_z, alpha, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, alpha, output ready);
endinterface

[hdl/hmn_fetch.sv]
// neighbor addressing, height store, differences and squared gradient sum
module hmn_fetch import hmn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  hmn_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [ROW_W-1:0] in_row,
  input  logic [COL_W-1:0] in_col,
  input  logic [SMP_W-1:0] in_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output hmn_grad_t        out_data
);

  logic [SMP_W-1:0] mem_a [MEM_DEPTH];
  logic [SMP_W-1:0] mem_b [MEM_DEPTH];

  logic [DIM_W-1:0] eff_w, eff_h;
  logic             in_rng;
  logic [ROW_W-1:0] r0, r1;
  logic [COL_W-1:0] c0, c1;

  logic              a_v_r, a_store_r;
  logic [ADDR_W-1:0] a_a00_r, a_a10_r, a_a01_r;
  logic [SMP_W-1:0]  a_smp_r;
  logic              b_v_r;
  logic [SMP_W-1:0]  b_h00_r, b_h10_r, b_h01_r;
  logic              c_v_r;
  logic signed [DIFF_W-1:0] c_dxn_r, c_dyn_r;
  logic              d_v_r;
  logic signed [DIFF_W-1:0] d_dxn_r, d_dyn_r;
  logic [SQ_W-1:0]   d_sqx_r, d_sqy_r;
  logic              e_v_r;
  hmn_grad_t         e_r;

  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;
  logic signed [DIFF_W-1:0] dx_ext, dy_ext, sc_ext;
  logic signed [DIFF_W-1:0] dx_neg, dy_neg;
  logic [DIFF_W-2:0]        dx_mag, dy_mag;

  assign eff_w  = (cfg.width > MAX_W_DIM) ? MAX_W_DIM : cfg.width;
  assign eff_h  = (cfg.height > MAX_H_DIM) ? MAX_H_DIM : cfg.height;
  assign in_rng = ({1'b0, in_row} < eff_h) && ({1'b0, in_col} < eff_w);

  // edge handling: wrap to the far edge or move the pair one step inward
  always_comb begin
    r0 = in_row;
    c0 = in_col;
    r1 = in_row - 1'b1;
    c1 = in_col - 1'b1;
    if (in_row == '0) begin
      if (cfg.wrap) begin
        r1 = ROW_W'(eff_h - 1'b1);
      end else if (eff_h > DIM_W'(1)) begin
        r0 = ROW_W'(1);
        r1 = '0;
      end else begin
        r1 = '0;
      end
    end
    if (in_col == '0) begin
      if (cfg.wrap) begin
        c1 = COL_W'(eff_w - 1'b1);
      end else if (eff_w > DIM_W'(1)) begin
        c0 = COL_W'(1);
        c1 = '0;
      end else begin
        c1 = '0;
      end
    end
  end

  assign e_rdy    = !e_v_r || out_ready;
  assign d_rdy    = !d_v_r || e_rdy;
  assign c_rdy    = !c_v_r || d_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (a_rdy) a_v_r <= in_valid && in_rng;
      if (b_rdy) b_v_r <= a_v_r && !a_store_r;
      if (c_rdy) c_v_r <= b_v_r;
      if (d_rdy) d_v_r <= c_v_r;
      if (e_rdy) e_v_r <= d_v_r;
    end
  end

  // a store uses the item's own coordinates
  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_store_r <= (in_opcode == OP_STORE);
      a_smp_r   <= in_sample;
      if (in_opcode == OP_STORE) begin
        a_a00_r <= {in_row, in_col};
      end else begin
        a_a00_r <= {r0, c0};
      end
      a_a10_r <= {r0, c1};
      a_a01_r <= {r1, c0};
    end
  end

  // two copies of the store give three read ports
  always_ff @(posedge clk) begin
    if (a_v_r && a_store_r && b_rdy) begin
      mem_a[a_a00_r] <= a_smp_r;
      mem_b[a_a00_r] <= a_smp_r;
    end
    if (b_rdy) begin
      b_h00_r <= mem_a[a_a00_r];
      b_h10_r <= mem_a[a_a10_r];
      b_h01_r <= mem_b[a_a01_r];
    end
  end

  assign dx_ext = DIFF_W'($signed({1'b0, b_h10_r}) - $signed({1'b0, b_h00_r}));
  assign dy_ext = DIFF_W'($signed({1'b0, b_h01_r}) - $signed({1'b0, b_h00_r}));
  assign sc_ext = DIFF_W'(cfg.scale);

  // squares are taken on magnitudes, which fit in one bit less
  assign dx_neg = -c_dxn_r;
  assign dy_neg = -c_dyn_r;
  assign dx_mag = c_dxn_r[DIFF_W-1] ? dx_neg[DIFF_W-2:0] : c_dxn_r[DIFF_W-2:0];
  assign dy_mag = c_dyn_r[DIFF_W-1] ? dy_neg[DIFF_W-2:0] : c_dyn_r[DIFF_W-2:0];

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_dxn_r <= dx_ext * sc_ext;
      c_dyn_r <= dy_ext * sc_ext;
    end
    if (d_rdy) begin
      d_dxn_r <= c_dxn_r;
      d_dyn_r <= c_dyn_r;
      d_sqx_r <= dx_mag * dx_mag;
      d_sqy_r <= dy_mag * dy_mag;
    end
    if (e_rdy) begin
      e_r.dxn      <= d_dxn_r;
      e_r.dyn      <= d_dyn_r;
      e_r.radicand <= d_sqx_r + d_sqy_r + UNIT_Z_SQ;
    end
  end

  assign out_valid = e_v_r;
  assign out_data  = e_r;

endmodule

[hdl/hmn_sqrt.sv]
// pipelined integer square root, two root bits per stage
module hmn_sqrt import hmn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hmn_grad_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output hmn_len_t  out_data
);

  localparam int NS    = ROOT_W / 2;
  localparam int REM_W = ROOT_W + 3;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dxn;
    logic signed [DIFF_W-1:0] dyn;
    logic [SQ_W-1:0]          rad;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
  } sq_st_t;

  function automatic sq_st_t sqrt_step2(sq_st_t s);
    sq_st_t           o;
    logic [REM_W-1:0] trial;
    o = s;
    for (int k = 0; k < 2; k++) begin
      o.rem = {o.rem[REM_W-3:0], o.rad[SQ_W-1 -: 2]};
      o.rad = {o.rad[SQ_W-3:0], 2'b00};
      trial = REM_W'({o.root, 2'b01});
      if (o.rem >= trial) begin
        o.rem  = o.rem - trial;
        o.root = {o.root[ROOT_W-2:0], 1'b1};
      end else begin
        o.root = {o.root[ROOT_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic   v_r  [NS];
  logic   rdy  [NS];
  sq_st_t st_r [NS];
  sq_st_t init;

  assign init = '{dxn: in_data.dxn, dyn: in_data.dyn, rad: in_data.radicand,
                  rem: '0, root: '0};

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic   src_v;
    sq_st_t src;
    if (s == 0) begin : g_first
      assign src_v = in_valid;
      assign src   = init;
    end else begin : g_next
      assign src_v = v_r[s-1];
      assign src   = st_r[s-1];
    end
    if (s == NS - 1) begin : g_last
      assign rdy[s] = !v_r[s] || out_ready;
    end else begin : g_mid
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= src_v;
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[s]) st_r[s] <= sqrt_step2(src);
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = v_r[NS-1];
  assign out_data.dxn   = st_r[NS-1].dxn;
  assign out_data.dyn   = st_r[NS-1].dyn;
  assign out_data.root  = st_r[NS-1].root;

endmodule

[hdl/hmn_div.sv]
// pipelined floor division of the three scaled components by the length
module hmn_div import hmn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hmn_len_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hmn_rgb_t out_data
);

  localparam int NS = Q_W + 1;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic [NUM_W-1:0]  rx;
    logic [NUM_W-1:0]  ry;
    logic [NUM_W-1:0]  rz;
    logic [Q_W-1:0]    qx;
    logic [Q_W-1:0]    qy;
    logic [Q_W-1:0]    qz;
    logic [ROOT_W-1:0] den;
  } dv_st_t;

  function automatic logic [NUM_W+Q_W-1:0] div_step(logic [NUM_W-1:0] r,
      logic [Q_W-1:0] q, logic [ROOT_W-1:0] den, int pos);
    logic [NUM_W-1:0] sh;
    logic [NUM_W-1:0] rn;
    logic [Q_W-1:0]   qn;
    sh = NUM_W'(den) << pos;
    rn = r;
    qn = q;
    if (r >= sh) begin
      rn      = r - sh;
      qn[pos] = 1'b1;
    end
    return {rn, qn};
  endfunction

  function automatic logic [7:0] to_byte(logic neg, logic [Q_W-1:0] q,
      logic [NUM_W-1:0] r);
    logic [7:0] qe;
    qe = 8'(q);
    if (neg) begin
      return BIAS - qe - 8'(r != '0);
    end else begin
      return BIAS + qe;
    end
  endfunction

  logic   v_r  [NS];
  logic   rdy  [NS];
  dv_st_t st_r [NS];
  logic   o_v_r, o_rdy;
  hmn_rgb_t o_r;

  logic signed [31:0] nx, ny;
  dv_st_t init;

  // 127 * d as a shift and subtract
  assign nx = (32'(in_data.dxn) <<< 7) - 32'(in_data.dxn);
  assign ny = (32'(in_data.dyn) <<< 7) - 32'(in_data.dyn);

  always_comb begin
    init.sx  = nx[31];
    init.sy  = ny[31];
    init.rx  = nx[31] ? NUM_W'(-nx) : NUM_W'(nx);
    init.ry  = ny[31] ? NUM_W'(-ny) : NUM_W'(ny);
    init.rz  = NUM_Z;
    init.qx  = '0;
    init.qy  = '0;
    init.qz  = '0;
    init.den = in_data.root;
  end

  assign o_rdy = !o_v_r || out_ready;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic   src_v;
    dv_st_t src, nxt;
    if (s == 0) begin : g_first
      assign src_v = in_valid;
      assign src   = init;
      assign nxt   = src;
    end else begin : g_step
      assign src_v = v_r[s-1];
      assign src   = st_r[s-1];
      always_comb begin
        nxt = src;
        {nxt.rx, nxt.qx} = div_step(src.rx, src.qx, src.den, Q_W - s);
        {nxt.ry, nxt.qy} = div_step(src.ry, src.qy, src.den, Q_W - s);
        {nxt.rz, nxt.qz} = div_step(src.rz, src.qz, src.den, Q_W - s);
      end
    end
    if (s == NS - 1) begin : g_last
      assign rdy[s] = !v_r[s] || o_rdy;
    end else begin : g_mid
      assign rdy[s] = !v_r[s] || rdy[s+1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= src_v;
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[s]) st_r[s] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      o_r.x <= to_byte(st_r[NS-1].sx, st_r[NS-1].qx, st_r[NS-1].rx);
      o_r.y <= to_byte(st_r[NS-1].sy, st_r[NS-1].qy, st_r[NS-1].ry);
      o_r.z <= to_byte(1'b0, st_r[NS-1].qz, st_r[NS-1].rz);
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule

[hdl/height_map_to_normal_map.sv]
// top level: register port, height store fetch, square root and divide pipeline
// Height map to normal map.
// in_chan carries items: opcode 0 stores height_sample at (row, col), opcode 1
// asks for the normal at (row, col) from its left and upper neighbors.
// out_chan returns one RGBA normal per in-range compute item, in order;
// stores and out-of-range items give nothing.
// The APB port sets the map width (0x0), the map height (0x4), bump_scale (0x8)
// and wrap_edges (0xC); write it only while no item is in flight.
// Throughput: one item per cycle while out_chan is not stalled. A compute item
// passes through address, store read, differences and squares, then the square
// root (two root bits per stage) and then the three parallel dividers.
// Every stage carries a valid bit and fills bubbles, so a stalled receiver
// holds its item while upstream stages keep taking items until full.
// Reset clears the pipeline and sets the registers to 256, 256, 256, 0;
// the height store is not cleared and must be written before it is read.
module height_map_to_normal_map import hmn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  hmn_in_if.sink                in_chan,
  hmn_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  hmn_cfg_t  cfg_r;
  logic      cfg_wr;
  logic      g_valid, g_ready, l_valid, l_ready, n_valid;
  hmn_grad_t g_data;
  hmn_len_t  l_data;
  hmn_rgb_t  n_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= MAX_W_DIM;
      cfg_r.height <= MAX_H_DIM;
      cfg_r.scale  <= 16'sd256;
      cfg_r.wrap   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg_r.width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_r.height <= pwdata[DIM_W-1:0];
        REG_SCALE:  cfg_r.scale  <= pwdata[SCALE_W-1:0];
        REG_WRAP:   cfg_r.wrap   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg_r.width);
      REG_HEIGHT: prdata = 32'(cfg_r.height);
      REG_SCALE:  prdata = 32'(cfg_r.scale);
      REG_WRAP:   prdata = 32'(cfg_r.wrap);
      default:    prdata = '0;
    endcase
  end

  hmn_fetch u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_opcode (in_chan.opcode),
    .in_row    (in_chan.row),
    .in_col    (in_chan.col),
    .in_sample (in_chan.height_sample),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_data  (g_data)
  );

  hmn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_data   (g_data),
    .out_valid (l_valid),
    .out_ready (l_ready),
    .out_data  (l_data)
  );

  hmn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (l_valid),
    .in_ready  (l_ready),
    .in_data   (l_data),
    .out_valid (n_valid),
    .out_ready (out_chan.ready),
    .out_data  (n_data)
  );

  assign out_chan.valid    = n_valid;
  assign out_chan.normal_x = n_data.x;
  assign out_chan.normal_y = n_data.y;
  assign out_chan.normal_z = n_data.z;
  assign out_chan.alpha    = ALPHA;

endmodule
